### src/bpc_pkg.sv
// ---------------------------------------------------------------------------
// bpc_pkg: shared types and constants for barometer compensation
// Coefficient constants, register indexes, divider request/response types
// and small helpers used by the datapath and the pipelined divider.
// ---------------------------------------------------------------------------
package bpc_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned DivSteps = 32;
  localparam int unsigned TagW     = 64;
  localparam int unsigned CfgIdxW  = 3;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegPairOne   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPairTwo   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPairThree = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPairFour  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegPairFive  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegOss       = 3'd5;

  // compensation constants
  localparam logic [DataW-1:0] TempOffset = 32'd4000;
  localparam logic [DataW-1:0] PresBias   = 32'd32768;
  localparam logic [DataW-1:0] PresScale  = 32'd50000;
  localparam logic [DataW-1:0] PolyA      = 32'd3038;
  localparam logic [DataW-1:0] PolyB      = 32'hFFFF_E343;
  localparam logic [DataW-1:0] PolyC      = 32'd3791;

  // request into and response out of the divider pipeline
  typedef struct packed {
    logic             vld;
    logic [DataW-1:0] num;
    logic [DataW-1:0] den;
    logic [TagW-1:0]  tag;
  } div_req_t;

  typedef struct packed {
    logic             vld;
    logic [DataW-1:0] quot;
    logic [TagW-1:0]  tag;
  } div_rsp_t;

  // sign extension of a 16-bit field
  function automatic logic [DataW-1:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // arithmetic right shift of a 32-bit word
  function automatic logic [DataW-1:0] asr(input logic [DataW-1:0] v,
                                           input logic [4:0] n);
    return DataW'($signed(v) >>> n);
  endfunction

endpackage

### src/bpc_ifs.sv
// ---------------------------------------------------------------------------
// bpc channel interfaces
// Valid/ready channels for raw samples in and compensated results out.
// ---------------------------------------------------------------------------
interface bpc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_temperature;
  logic [18:0] raw_pressure;

  modport source(output valid, output raw_temperature, output raw_pressure,
                 input ready);
  modport sink(input valid, input raw_temperature, input raw_pressure,
               output ready);
endinterface

interface bpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] true_temperature;
  logic signed [31:0] true_pressure;
  logic               divide_fault;

  modport source(output valid, output true_temperature, output true_pressure,
                 output divide_fault, input ready);
  modport sink(input valid, input true_temperature, input true_pressure,
               input divide_fault, output ready);
endinterface

### src/bpc_div.sv
// ---------------------------------------------------------------------------
// bpc_div: pipelined unsigned 32/32 divider
// Restoring division, one quotient bit per stage, a tag travels alongside.
// ---------------------------------------------------------------------------
module bpc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  bpc_pkg::div_req_t req,
  output bpc_pkg::div_rsp_t rsp
);
  import bpc_pkg::*;

  logic             vld_r [DivSteps];
  logic [DataW-1:0] rem_r [DivSteps];
  logic [DataW-1:0] num_r [DivSteps];
  logic [DataW-1:0] den_r [DivSteps];
  logic [TagW-1:0]  tag_r [DivSteps];

  logic             vld_in [DivSteps];
  logic [DataW-1:0] rem_in [DivSteps];
  logic [DataW-1:0] num_in [DivSteps];
  logic [DataW-1:0] den_in [DivSteps];
  logic [TagW-1:0]  tag_in [DivSteps];
  logic [DataW:0]   trial  [DivSteps];
  logic [DataW:0]   diff   [DivSteps];
  logic             ge     [DivSteps];
  logic [DataW-1:0] rem_nxt [DivSteps];
  logic [DataW-1:0] num_nxt [DivSteps];

  // one trial subtraction per stage
  always_comb begin
    for (int k = 0; k < DivSteps; k++) begin
      if (k == 0) begin
        vld_in[k] = req.vld;
        rem_in[k] = '0;
        num_in[k] = req.num;
        den_in[k] = req.den;
        tag_in[k] = req.tag;
      end else begin
        vld_in[k] = vld_r[k-1];
        rem_in[k] = rem_r[k-1];
        num_in[k] = num_r[k-1];
        den_in[k] = den_r[k-1];
        tag_in[k] = tag_r[k-1];
      end
      trial[k]   = {rem_in[k], num_in[k][DataW-1]};
      diff[k]    = trial[k] - {1'b0, den_in[k]};
      ge[k]      = trial[k] >= {1'b0, den_in[k]};
      rem_nxt[k] = ge[k] ? diff[k][DataW-1:0] : trial[k][DataW-1:0];
      num_nxt[k] = {num_in[k][DataW-2:0], ge[k]};
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DivSteps; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < DivSteps; k++) vld_r[k] <= vld_in[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DivSteps; k++) begin
        rem_r[k] <= rem_nxt[k];
        num_r[k] <= num_nxt[k];
        den_r[k] <= den_in[k];
        tag_r[k] <= tag_in[k];
      end
    end
  end

  assign rsp.vld  = vld_r[DivSteps-1];
  assign rsp.quot = num_r[DivSteps-1];
  assign rsp.tag  = tag_r[DivSteps-1];

endmodule

### src/baro_pressure_temp_compensation.sv
// ---------------------------------------------------------------------------
// baro_pressure_temp_compensation: integer barometer compensation
// Turns raw temperature and pressure words into 0.1 degC and pascals.
// ---------------------------------------------------------------------------
// Usage:
//   in_chan carries one request (raw temperature, raw pressure) per handshake;
//   out_chan returns one result (temperature, pressure, divide fault) for each.
//   Calibration pairs and the oversampling setting are written through
//   cfg_we / cfg_index / cfg_wdata while no request is in flight.
// Pipeline: two 32-stage one-bit-per-stage dividers plus eleven arithmetic
//   stages lie between acceptance and out_chan.valid.
// Throughput: one request per cycle while not stalled; every stage, divider
//   stages included, is registered and a new request enters each cycle.
// Stall: when a result waits and out_chan.ready is low the whole pipeline
//   holds; in_chan.ready drops with it and nothing is lost or repeated.
// Reset: rst_n (synchronous, active low) empties the pipeline, clears the
//   calibration pairs and sets oversampling to 1.
// A zero divisor gives zero results with divide_fault set.
// ---------------------------------------------------------------------------
module baro_pressure_temp_compensation (
  input  logic                          clk,
  input  logic                          rst_n,
  bpc_in_if.sink                        in_chan,
  bpc_out_if.source                     out_chan,
  input  logic                          cfg_we,
  input  logic [bpc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [bpc_pkg::DataW-1:0]     cfg_wdata
);
  import bpc_pkg::*;

  logic [31:0] pair1_r, pair2_r, pair3_r, pair4_r, pair5_r;
  logic [1:0]  oss_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair1_r <= '0;
      pair2_r <= '0;
      pair3_r <= '0;
      pair4_r <= '0;
      pair5_r <= '0;
      oss_r   <= 2'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        RegPairOne:   pair1_r <= cfg_wdata;
        RegPairTwo:   pair2_r <= cfg_wdata;
        RegPairThree: pair3_r <= cfg_wdata;
        RegPairFour:  pair4_r <= cfg_wdata;
        RegPairFive:  pair5_r <= cfg_wdata;
        RegOss:       oss_r   <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // coefficients
  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = sx16(pair1_r[31:16]);
  assign ac2 = sx16(pair1_r[15:0]);
  assign ac3 = sx16(pair2_r[31:16]);
  assign ac4 = {16'd0, pair2_r[15:0]};
  assign ac5 = {16'd0, pair3_r[31:16]};
  assign ac6 = {16'd0, pair3_r[15:0]};
  assign b1  = sx16(pair4_r[31:16]);
  assign b2  = sx16(pair4_r[15:0]);
  assign mc  = sx16(pair5_r[31:16]);
  assign md  = sx16(pair5_r[15:0]);

  logic adv;
  logic out_vld_r;
  assign adv           = !out_vld_r || out_chan.ready;
  assign in_chan.ready = adv;

  // valid bits of the arithmetic stages
  logic a_vld_r, b_vld_r, d_vld_r, e_vld_r, f_vld_r, g_vld_r;
  logic h_vld_r, i_vld_r, k_vld_r, l_vld_r;
  div_req_t req1, req2;
  div_rsp_t rsp1, rsp2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      d_vld_r   <= 1'b0;
      e_vld_r   <= 1'b0;
      f_vld_r   <= 1'b0;
      g_vld_r   <= 1'b0;
      h_vld_r   <= 1'b0;
      i_vld_r   <= 1'b0;
      k_vld_r   <= 1'b0;
      l_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r   <= in_chan.valid;
      b_vld_r   <= a_vld_r;
      d_vld_r   <= rsp1.vld;
      e_vld_r   <= d_vld_r;
      f_vld_r   <= e_vld_r;
      g_vld_r   <= f_vld_r;
      h_vld_r   <= g_vld_r;
      i_vld_r   <= h_vld_r;
      k_vld_r   <= rsp2.vld;
      l_vld_r   <= k_vld_r;
      out_vld_r <= l_vld_r;
    end
  end

  // stage a: temperature difference product
  logic [31:0] a_prod_r;
  logic [18:0] a_up_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      a_prod_r <= ({16'd0, in_chan.raw_temperature} - ac6) * ac5;
      a_up_r   <= in_chan.raw_pressure;
    end
  end

  // stage b: x1 and temperature divisor
  logic [31:0] b_x1_r, b_den_r;
  logic [18:0] b_up_r;
  logic [31:0] x1_a;
  assign x1_a = asr(a_prod_r, 5'd15);
  always_ff @(posedge clk) begin
    if (adv) begin
      b_x1_r  <= x1_a;
      b_den_r <= x1_a + md;
      b_up_r  <= a_up_r;
    end
  end

  // first division: (mc << 11) / (x1 + md), signed via magnitudes
  logic [31:0] num1;
  logic        neg1, zero1;
  assign num1  = mc << 11;
  assign neg1  = num1[31] ^ b_den_r[31];
  assign zero1 = (b_den_r == '0);
  assign req1.vld = b_vld_r;
  assign req1.num = num1[31] ? 32'(-num1) : num1;
  assign req1.den = b_den_r[31] ? 32'(-b_den_r) : b_den_r;
  assign req1.tag = {11'd0, zero1, neg1, b_up_r, b_x1_r};

  bpc_div u_div_temp (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .req   (req1),
    .rsp   (rsp1)
  );

  // stage d: b5, true temperature, b6
  logic [31:0] x2_d, b5_d;
  logic [31:0] d_t_r, d_b6_r;
  logic [18:0] d_up_r;
  logic        d_fault_r;
  assign x2_d = rsp1.tag[51] ? 32'(-rsp1.quot) : rsp1.quot;
  assign b5_d = rsp1.tag[31:0] + x2_d;
  always_ff @(posedge clk) begin
    if (adv) begin
      d_t_r     <= asr(b5_d + 32'd8, 5'd4);
      d_b6_r    <= b5_d - TempOffset;
      d_up_r    <= rsp1.tag[50:32];
      d_fault_r <= rsp1.tag[52];
    end
  end

  // stage e: products on b6
  logic [31:0] e_p1_r, e_p2_r, e_p3_r, e_t_r;
  logic [18:0] e_up_r;
  logic        e_fault_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      e_p1_r    <= d_b6_r * d_b6_r;
      e_p2_r    <= ac2 * d_b6_r;
      e_p3_r    <= ac3 * d_b6_r;
      e_t_r     <= d_t_r;
      e_up_r    <= d_up_r;
      e_fault_r <= d_fault_r;
    end
  end

  // stage f: second-order products on the squared term, shifted first-order terms
  logic [31:0] sq_e;
  logic [31:0] f_m1_r, f_m2_r, f_x2_r, f_x1c_r, f_t_r;
  logic [18:0] f_up_r;
  logic        f_fault_r;
  assign sq_e = asr(e_p1_r, 5'd12);
  always_ff @(posedge clk) begin
    if (adv) begin
      f_m1_r    <= b2 * sq_e;
      f_m2_r    <= b1 * sq_e;
      f_x2_r    <= asr(e_p2_r, 5'd11);
      f_x1c_r   <= asr(e_p3_r, 5'd13);
      f_t_r     <= e_t_r;
      f_up_r    <= e_up_r;
      f_fault_r <= e_fault_r;
    end
  end

  // stage g: b3 and x3 for b4
  logic [31:0] x3_f, b3_sum;
  logic [31:0] g_b3_r, g_x3_r, g_t_r;
  logic [18:0] g_up_r;
  logic        g_fault_r;
  assign x3_f   = asr(f_m1_r, 5'd11) + f_x2_r;
  assign b3_sum = (((ac1 << 2) + x3_f) << oss_r) + 32'd2;
  always_ff @(posedge clk) begin
    if (adv) begin
      g_b3_r    <= asr(b3_sum, 5'd2);
      g_x3_r    <= asr(asr(f_m2_r, 5'd16) + f_x1c_r + 32'd2, 5'd2);
      g_t_r     <= f_t_r;
      g_up_r    <= f_up_r;
      g_fault_r <= f_fault_r;
    end
  end

  // stage h: b4 product and pressure difference
  logic [31:0] h_b4p_r, h_diff_r, h_t_r;
  logic        h_fault_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      h_b4p_r   <= ac4 * (g_x3_r + PresBias);
      h_diff_r  <= {13'd0, g_up_r} - g_b3_r;
      h_t_r     <= g_t_r;
      h_fault_r <= g_fault_r;
    end
  end

  // stage i: b4 and b7
  logic [31:0] i_b4_r, i_b7_r, i_t_r;
  logic        i_fault_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      i_b4_r    <= h_b4p_r >> 15;
      i_b7_r    <= h_diff_r * (PresScale >> oss_r);
      i_t_r     <= h_t_r;
      i_fault_r <= h_fault_r;
    end
  end

  // second division: b7 / b4, doubling before or after by the top bit of b7
  logic hi2, fault2;
  assign hi2    = i_b7_r[31];
  assign fault2 = i_fault_r || (i_b4_r == '0);
  assign req2.vld = i_vld_r;
  assign req2.num = hi2 ? i_b7_r : (i_b7_r << 1);
  assign req2.den = i_b4_r;
  assign req2.tag = {30'd0, hi2, fault2, i_t_r};

  bpc_div u_div_pres (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .req   (req2),
    .rsp   (rsp2)
  );

  // stage k: p and its correction products
  logic [31:0] p_k, s_k;
  logic [31:0] k_p_r, k_sq_r, k_pm_r, k_t_r;
  logic        k_fault_r;
  assign p_k = rsp2.tag[33] ? (rsp2.quot << 1) : rsp2.quot;
  assign s_k = asr(p_k, 5'd8);
  always_ff @(posedge clk) begin
    if (adv) begin
      k_p_r     <= p_k;
      k_sq_r    <= s_k * s_k;
      k_pm_r    <= PolyB * p_k;
      k_t_r     <= rsp2.tag[31:0];
      k_fault_r <= rsp2.tag[32];
    end
  end

  // stage l: scale of the squared term and of the linear term
  logic [31:0] l_p_r, l_m3_r, l_x2_r, l_t_r;
  logic        l_fault_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      l_p_r     <= k_p_r;
      l_m3_r    <= k_sq_r * PolyA;
      l_x2_r    <= asr(k_pm_r, 5'd16);
      l_t_r     <= k_t_r;
      l_fault_r <= k_fault_r;
    end
  end

  // output register: final pressure, fault forces zero results
  logic [31:0] pres_l;
  logic [31:0] out_t_r, out_p_r;
  logic        out_fault_r;
  assign pres_l = l_p_r + asr(asr(l_m3_r, 5'd16) + l_x2_r + PolyC, 5'd4);
  always_ff @(posedge clk) begin
    if (adv) begin
      out_t_r     <= l_fault_r ? '0 : l_t_r;
      out_p_r     <= l_fault_r ? '0 : pres_l;
      out_fault_r <= l_fault_r;
    end
  end

  assign out_chan.valid            = out_vld_r;
  assign out_chan.true_temperature = $signed(out_t_r);
  assign out_chan.true_pressure    = $signed(out_p_r);
  assign out_chan.divide_fault     = out_fault_r;

endmodule
